[src/session_table_idle_timeout_macros.svh]
// assertion macros for the session table with idle timeout
// expects clock and reset in the scope of each use

`ifndef SESSION_TABLE_IDLE_TIMEOUT_MACROS_SVH
`define SESSION_TABLE_IDLE_TIMEOUT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define STIT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define STIT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/stit_pkg.sv]
// shared types, constants and helpers of the session table with idle timeout
// no dependencies

package stit_pkg;

   localparam int ENTRIES    = 64;
   localparam int IDX_W      = $clog2(ENTRIES);
   localparam int CNT_W      = $clog2(ENTRIES + 1);

   localparam int ACTION_W   = 3;
   localparam int KEY_W      = 32;
   localparam int ADDR_W     = 32;
   localparam int PORT_W     = 16;
   localparam int TIME_W     = 32;
   localparam int PKT_W      = 32;
   localparam int TIMEOUT_W  = 16;
   localparam int STATUS_W   = 2;
   localparam int ACTIVE_W   = 7;
   localparam int REMOVED_W  = 7;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(300);

   localparam int REQ_USER_W  = ACTION_W;
   localparam int REQ_DATA_W  = ((KEY_W + ADDR_W + PORT_W + 7) / 8) * 8;
   localparam int RSP_USER_W  = STATUS_W;
   localparam int RSP_FIELD_W = KEY_W + ADDR_W + PORT_W + PKT_W + 2 * TIME_W
                                + ACTIVE_W + REMOVED_W;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int ACTIVE_LSB  = KEY_W + ADDR_W + PORT_W + PKT_W + 2 * TIME_W;

   typedef enum logic [ACTION_W-1:0] {
      ACT_CREATE = 3'd0,
      ACT_LOOKUP = 3'd1,
      ACT_TOUCH  = 3'd2,
      ACT_CLOSE  = 3'd3,
      ACT_TICK   = 3'd4,
      ACT_SWEEP  = 3'd5
   } stit_action_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK        = 2'd0,
      STS_NOT_FOUND = 2'd1,
      STS_FULL      = 2'd2
   } stit_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_ENCODE,
      S_SWEEP_RD,
      S_SWEEP_CHK,
      S_FINISH
   } stit_state_type;

   // one table entry as held in the ram, the key lives in flops
   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [PORT_W-1:0] port;
      logic [TIME_W-1:0] created;
      logic [TIME_W-1:0] last;
      logic [PKT_W-1:0]  packets;
   } stit_entry_type;

   localparam int ENTRY_W = $bits(stit_entry_type);

   typedef struct packed {
      logic load;
      logic decode;
      logic encode;
      logic sweep_read;
      logic sweep_check;
      logic commit;
   } stit_cmd_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                scan_last;
      logic                out_free;
   } stit_sts_type;

   // lowest set bit of a vector
   function automatic logic [IDX_W-1:0] first_index(input logic [ENTRIES-1:0] vec);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (vec[i]) begin
            idx = IDX_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

[src/stit_ram.sv]
// generic simple dual port ram with registered read
// no dependencies

module stit_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/stit_ctrl.sv]
// operation sequencer of the session table
// depends on stit_pkg

module stit_ctrl import stit_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  stit_sts_type sts,
   output stit_cmd_type cmd
);

   stit_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.action inside {ACT_LOOKUP, ACT_TOUCH, ACT_CLOSE}) begin
               state_in = S_ENCODE;
            end else if (sts.action == ACT_SWEEP) begin
               state_in = S_SWEEP_RD;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_ENCODE:    state_in = S_FINISH;
         S_SWEEP_RD:  state_in = S_SWEEP_CHK;
         S_SWEEP_CHK: begin
            state_in = sts.scan_last ? S_FINISH : S_SWEEP_RD;
         end
         S_FINISH: begin
            if (sts.out_free) begin
               state_in = S_IDLE;
            end
         end
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_tready      = (state_ff == S_IDLE);
      cmd             = '0;
      cmd.load        = (state_ff == S_IDLE) && req_tvalid;
      cmd.decode      = (state_ff == S_DECODE);
      cmd.encode      = (state_ff == S_ENCODE);
      cmd.sweep_read  = (state_ff == S_SWEEP_RD);
      cmd.sweep_check = (state_ff == S_SWEEP_CHK);
      cmd.commit      = (state_ff == S_FINISH) && sts.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/stit_dpath.sv]
// table storage, key match, sweep scan and result register
// depends on stit_pkg and stit_ram

module stit_dpath import stit_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  stit_cmd_type          cmd,
   output stit_sts_type          sts,
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  csr_wr_en,
   input  logic [TIMEOUT_W-1:0]  csr_wr_data,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_USER_W-1:0] rsp_tuser,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // request beat
   logic [ACTION_W-1:0]   action_ff;
   logic [KEY_W-1:0]      key_ff;
   logic [ADDR_W-1:0]     addr_ff;
   logic [PORT_W-1:0]     port_ff;

   // table and counters
   logic [TIMEOUT_W-1:0]  idle_timeout_ff, idle_timeout_in;
   logic [ENTRIES-1:0]    valid_ff, valid_in;
   logic [KEY_W-1:0]      keys_ff [ENTRIES];
   logic                  key_we;
   logic [KEY_W-1:0]      next_key_ff, next_key_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic [CNT_W-1:0]      held_ff, held_in;

   // working registers
   logic [ENTRIES-1:0]    match_ff, match_in;
   logic [IDX_W-1:0]      free_idx_ff;
   logic                  full_ff;
   logic [IDX_W-1:0]      hit_idx_ff, hit_idx;
   logic                  found_ff;
   logic [IDX_W-1:0]      scan_ff, scan_in;
   logic [CNT_W-1:0]      removed_ff, removed_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // ram
   logic                  ram_wr_en;
   logic [IDX_W-1:0]      ram_wr_addr;
   stit_entry_type        ram_wr_data;
   logic                  ram_rd_en;
   logic [IDX_W-1:0]      ram_rd_addr;
   stit_entry_type        ram_rd_data;

   stit_entry_type        touched;
   stit_entry_type        shown;
   logic [TIME_W-1:0]     age;
   logic                  expired;
   logic                  out_free;
   stit_status_type       r_status;
   logic [KEY_W-1:0]      r_key;

   stit_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign out_free      = !rsp_valid_ff || rsp_tready;
   assign hit_idx       = first_index(match_ff);
   assign ram_rd_en     = cmd.encode || cmd.sweep_read;
   assign ram_rd_addr   = cmd.sweep_read ? scan_ff : hit_idx;

   assign sts.action    = action_ff;
   assign sts.scan_last = (scan_ff == IDX_W'(ENTRIES - 1));
   assign sts.out_free  = out_free;

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match_in[i] = valid_ff[i] && (keys_ff[i] == key_ff);
      end
   end

   always_comb begin
      touched      = ram_rd_data;
      touched.last = now_ff;
      if (ram_rd_data.packets != '1) begin
         touched.packets = ram_rd_data.packets + PKT_W'(1);
      end
      age     = now_ff - ram_rd_data.last;
      expired = valid_ff[scan_ff] && (age > TIME_W'(idle_timeout_ff));
   end

   always_comb begin
      idle_timeout_in = csr_wr_en ? csr_wr_data : idle_timeout_ff;
      valid_in        = valid_ff;
      key_we          = 1'b0;
      next_key_in     = next_key_ff;
      now_in          = now_ff;
      held_in         = held_ff;
      scan_in         = scan_ff;
      removed_in      = removed_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = free_idx_ff;
      ram_wr_data     = '0;
      shown           = '0;
      r_status        = STS_OK;
      r_key           = '0;

      if (cmd.decode) begin
         scan_in    = '0;
         removed_in = '0;
      end

      if (cmd.sweep_check) begin
         scan_in = scan_ff + IDX_W'(1);
         if (expired) begin
            valid_in[scan_ff] = 1'b0;
            held_in           = held_ff - CNT_W'(1);
            removed_in        = removed_ff + CNT_W'(1);
         end
      end

      if (cmd.commit) begin
         case (action_ff)
            ACT_CREATE: begin
               if (full_ff) begin
                  r_status = STS_FULL;
               end else begin
                  ram_wr_en             = 1'b1;
                  ram_wr_data.address   = addr_ff;
                  ram_wr_data.port      = port_ff;
                  ram_wr_data.created   = now_ff;
                  ram_wr_data.last      = now_ff;
                  ram_wr_data.packets   = '0;
                  valid_in[free_idx_ff] = 1'b1;
                  key_we                = 1'b1;
                  held_in               = held_ff + CNT_W'(1);
                  next_key_in           = (next_key_ff == '1) ? KEY_W'(1)
                                                              : next_key_ff + KEY_W'(1);
                  shown                 = ram_wr_data;
                  r_key                 = next_key_ff;
               end
            end
            ACT_LOOKUP, ACT_TOUCH, ACT_CLOSE: begin
               r_key = key_ff;
               if (!found_ff) begin
                  r_status = STS_NOT_FOUND;
               end else if (action_ff == ACT_TOUCH) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = hit_idx_ff;
                  ram_wr_data = touched;
                  shown       = touched;
               end else begin
                  shown = ram_rd_data;
                  if (action_ff == ACT_CLOSE) begin
                     valid_in[hit_idx_ff] = 1'b0;
                     held_in              = held_ff - CNT_W'(1);
                  end
               end
            end
            ACT_TICK: begin
               now_in = now_ff + TIME_W'(1);
            end
            default: begin
            end
         endcase
      end

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_user_in  = rsp_user_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         rsp_user_in  = r_status;
         rsp_data_in  = RSP_DATA_W'({
            (action_ff == ACT_SWEEP) ? REMOVED_W'(removed_ff) : REMOVED_W'(0),
            ACTIVE_W'(held_in),
            shown.last,
            shown.created,
            shown.packets,
            shown.port,
            shown.address,
            r_key
         });
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_timeout_ff <= TIMEOUT_RESET;
         valid_ff        <= '0;
         next_key_ff     <= KEY_W'(1);
         now_ff          <= '0;
         held_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         idle_timeout_ff <= idle_timeout_in;
         valid_ff        <= valid_in;
         next_key_ff     <= next_key_in;
         now_ff          <= now_in;
         held_ff         <= held_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_tuser;
         key_ff    <= req_tdata[KEY_W-1:0];
         addr_ff   <= req_tdata[KEY_W +: ADDR_W];
         port_ff   <= req_tdata[KEY_W + ADDR_W +: PORT_W];
      end
      if (cmd.decode) begin
         match_ff    <= match_in;
         free_idx_ff <= first_index(~valid_ff);
         full_ff     <= &valid_ff;
      end
      if (cmd.encode) begin
         hit_idx_ff <= hit_idx;
         found_ff   <= |match_ff;
      end
      if (key_we) begin
         keys_ff[free_idx_ff] <= next_key_ff;
      end
      scan_ff     <= scan_in;
      removed_ff  <= removed_in;
      rsp_user_ff <= rsp_user_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[src/session_table_idle_timeout.sv]
// channel | direction | handshake            | payload
// req     | in        | req_tvalid/req_tready | tuser action, tdata key, address, port
// rsp     | out       | rsp_tvalid/rsp_tready | tuser status, tdata entry and counts
// csr     | in        | csr_wr_en             | csr_wr_data idle timeout
//
// one operation at a time: create, tick and unused actions pass decode and finish,
// lookup, touch and close also pass encode (key match, then encode and ram read)
// sweep passes decode, then a ram read and an age check for each entry, then finish
// a held result beat stalls the final step until rsp_tready frees the output register
// synchronous reset clears all valid bits at once, no clearing pass; timeout resets to 300
//
// top level of the session table with idle timeout
// depends on stit_pkg, stit_ctrl, stit_dpath and the macros header

`include "session_table_idle_timeout_macros.svh"

module session_table_idle_timeout import stit_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_USER_W-1:0] req_tuser,   // action
   input  logic [REQ_DATA_W-1:0] req_tdata,   // session_key, client_address, source port
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_USER_W-1:0] rsp_tuser,   // status
   // result_key, result_address, result_port, packet_count, created_time,
   // last_time, active_count, removed_count, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_wr_en,
   input  logic [TIMEOUT_W-1:0]  csr_wr_data  // idle_timeout
);

   stit_cmd_type cmd;
   stit_sts_type sts;

   stit_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   stit_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata)
   );

   `STIT_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready,
                     "beat taken while busy")
   `STIT_ASSERT_SAME(a_commit_slot_free, cmd.commit, !rsp_tvalid || rsp_tready,
                     "result overwritten")
   `STIT_ASSERT_SAME(a_full_count, rsp_tvalid && (rsp_tuser == STS_FULL),
                     rsp_tdata[ACTIVE_LSB +: ACTIVE_W] == ACTIVE_W'(ENTRIES),
                     "full with free slots")

endmodule
